// File: hdl/akdp_pkg.sv
// Shared constants, types and the control store of the ANOVA kernel unit.
`default_nettype none

package akdp_pkg;

	localparam int MAX_DEGREE_DEF = 8;

	localparam int A_W       = 16;
	localparam int X_W       = 20;   // floor(a*b / 4096) of two Q4.12 values
	localparam int SUM_W     = 48;
	localparam int HALF_W    = 24;   // split of a sum for the partial products
	localparam int PLO_W     = X_W + HALF_W + 1;
	localparam int PHI_W     = X_W + HALF_W;
	localparam int PROD_W    = 68;
	localparam int FRAC_W    = 12;
	localparam int TERM_W    = PROD_W - FRAC_W;
	localparam int ACC_W     = TERM_W + 1;
	localparam int DEG_W     = 4;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic signed [SUM_W-1:0] ONE_Q12 = SUM_W'(4096);
	localparam logic [0:0]              REG_DEGREE = 1'b0;

	typedef logic [2:0] step_t;

	localparam step_t ST_WAIT = 3'd0;
	localparam step_t ST_PROD = 3'd1;
	localparam step_t ST_MAC  = 3'd2;
	localparam step_t ST_DRN1 = 3'd3;
	localparam step_t ST_DRN2 = 3'd4;
	localparam step_t ST_DRN3 = 3'd5;
	localparam step_t ST_EMIT = 3'd6;

	typedef enum logic [2:0] {
		CND_NEVER    = 3'd0,
		CND_NO_IN    = 3'd1,
		CND_J_MORE   = 3'd2,
		CND_NOT_LAST = 3'd3,
		CND_OUT_BUSY = 3'd4
	} cond_t;

	typedef struct packed {
		logic  take;   // open the input side
		logic  prod;   // form x, read the top sum
		logic  mac;    // issue one sum update
		logic  emit;   // load the result word, clear sums
		cond_t cond;
		step_t jmp;    // taken when cond holds
		step_t nxt;    // taken otherwise
	} ucode_t;

	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		w = '{take: 1'b0, prod: 1'b0, mac: 1'b0, emit: 1'b0,
			cond: CND_NEVER, jmp: ST_WAIT, nxt: ST_WAIT};
		unique case (s)
			ST_WAIT: begin
				w.take = 1'b1;
				w.cond = CND_NO_IN;
				w.jmp  = ST_WAIT;
				w.nxt  = ST_PROD;
			end
			ST_PROD: begin
				w.prod = 1'b1;
				w.nxt  = ST_MAC;
			end
			ST_MAC: begin
				w.mac  = 1'b1;
				w.cond = CND_J_MORE;
				w.jmp  = ST_MAC;
				w.nxt  = ST_DRN1;
			end
			ST_DRN1: w.nxt = ST_DRN2;
			ST_DRN2: w.nxt = ST_DRN3;
			ST_DRN3: begin
				w.cond = CND_NOT_LAST;
				w.jmp  = ST_WAIT;
				w.nxt  = ST_EMIT;
			end
			ST_EMIT: begin
				w.emit = 1'b1;
				w.cond = CND_OUT_BUSY;
				w.jmp  = ST_EMIT;
				w.nxt  = ST_WAIT;
			end
			default: w.nxt = ST_WAIT;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: hdl/anova_kernel_dp_unit.sv
// ANOVA kernel unit: microcoded sequencer over a shared Q.12 multiply-accumulate.
// A word goes through the product step, the updates of e_d..e_1 by the one shared
//   multiply-accumulate and its three-stage drain; a last word then goes to the emit step,
//   which waits while the output is stalled. Words are taken only at the wait step.
// Reset (arst_n low, asynchronous): sums and overflow flag cleared, degree = 1,
//   sequencer at its wait step, no result pending.
`default_nettype none

module anova_kernel_dp_unit
	import akdp_pkg::*;
#(
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// stream in
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [31:0]        s_tdata,   // [15:0] a_value, [31:16] b_value
	input  wire logic               s_tlast,   // last_element
	// stream out
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [47:0]             m_tdata,   // [47:0] kernel_value
	output logic [0:0]              m_tuser,   // [0] saturated
	// register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

	// register port
	logic [DEG_W-1:0] degree_q;
	logic [DW-1:0]    d_eff;

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_DEGREE) ?
		{{(PDATA_W-DEG_W){1'b0}}, degree_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEG_W'(1);
		end else if (psel && penable && pwrite && pready &&
				paddr[PADDR_W-1:2] == REG_DEGREE) begin
			degree_q <= pwdata[DEG_W-1:0];
		end
	end

	always_comb begin
		if (degree_q == '0) begin
			d_eff = DW'(1);
		end else if (32'(degree_q) > MAX_DEGREE) begin
			d_eff = DW'(MAX_DEGREE);
		end else begin
			d_eff = DW'(degree_q);
		end
	end

	// sequencer
	step_t  step_q;
	ucode_t uc;
	logic   cond_hit;
	logic   out_busy;
	logic   emit_fire;
	logic   last_q;
	logic [DW-1:0] j_q;

	assign uc        = ucode_rom(step_q);
	assign s_tready  = uc.take;
	assign out_busy  = m_tvalid && !m_tready;
	assign emit_fire = uc.emit && !out_busy;

	always_comb begin
		unique case (uc.cond)
			CND_NEVER:    cond_hit = 1'b0;
			CND_NO_IN:    cond_hit = !s_tvalid;
			CND_J_MORE:   cond_hit = (j_q != '0);
			CND_NOT_LAST: cond_hit = !last_q;
			CND_OUT_BUSY: cond_hit = out_busy;
			default:      cond_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else begin
			step_q <= cond_hit ? uc.jmp : uc.nxt;
		end
	end

	// input word and product
	logic signed [A_W-1:0]   a_q, b_q;
	logic signed [2*A_W-1:0] ab;
	logic signed [X_W-1:0]   x_q;

	assign ab = a_q * b_q;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			a_q    <= s_tdata[A_W-1:0];
			b_q    <= s_tdata[2*A_W-1:A_W];
			last_q <= s_tlast;
		end
		if (uc.prod) begin
			x_q <= ab[2*A_W-1:FRAC_W];   // floor of the Q.12 product
		end
	end

	// running sums e_1..e_MAX, e_0 is the constant one
	logic signed [SUM_W-1:0] sums_q [MAX_DEGREE];
	logic                    ov_q;
	logic [DW-1:0]           rj;
	logic [DW-1:0]           rj_m1;
	logic signed [SUM_W-1:0] rval;
	logic signed [SUM_W-1:0] rd_q;

	assign rj    = uc.prod ? d_eff : j_q;
	assign rj_m1 = rj - DW'(1);
	assign rval  = (rj == '0) ? ONE_Q12 : sums_q[rj_m1[IW-1:0]];

	always_ff @(posedge clk) begin
		if (uc.prod) begin
			j_q <= d_eff - DW'(1);
		end else if (uc.mac && j_q != '0) begin
			j_q <= j_q - DW'(1);
		end
		if (uc.prod || uc.mac) begin
			rd_q <= rval;
		end
	end

	// stage 1: operands of e_k update, prev = e_(k-1), old = e_k
	logic                    v_s1;
	logic signed [SUM_W-1:0] prev_s1, old_s1;
	logic [DW-1:0]           tgt_s1;
	// stage 2: partial products
	logic                    v_s2;
	logic signed [PLO_W-1:0] plo_s2;
	logic signed [PHI_W-1:0] phi_s2;
	logic signed [SUM_W-1:0] old_s2;
	logic [DW-1:0]           tgt_s2;
	// stage 3: shifted term
	logic                     v_s3;
	logic signed [TERM_W-1:0] term_s3;
	logic signed [SUM_W-1:0]  old_s3;
	logic [DW-1:0]            tgt_s3;

	logic signed [PROD_W-1:0] prod_full;
	logic signed [ACC_W-1:0]  acc;
	logic signed [SUM_W-1:0]  sat_val;
	logic                     sat_hit;
	logic [DW-1:0]            wr_m1;
	logic signed [SUM_W-1:0]  kres_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= uc.mac;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prev_s1 <= rval;
		old_s1  <= rd_q;
		tgt_s1  <= j_q + DW'(1);

		plo_s2 <= x_q * $signed({1'b0, prev_s1[HALF_W-1:0]});
		phi_s2 <= x_q * $signed(prev_s1[SUM_W-1:HALF_W]);
		old_s2 <= old_s1;
		tgt_s2 <= tgt_s1;

		term_s3 <= prod_full[PROD_W-1:FRAC_W];
		old_s3  <= old_s2;
		tgt_s3  <= tgt_s2;
	end

	assign prod_full = ({{(PROD_W-PHI_W){phi_s2[PHI_W-1]}}, phi_s2} <<< HALF_W)
		+ {{(PROD_W-PLO_W){plo_s2[PLO_W-1]}}, plo_s2};

	assign acc = {{(ACC_W-SUM_W){old_s3[SUM_W-1]}}, old_s3}
		+ {term_s3[TERM_W-1], term_s3};

	always_comb begin
		sat_hit = (acc[ACC_W-1:SUM_W-1] != '0) && (acc[ACC_W-1:SUM_W-1] != '1);
		if (!sat_hit) begin
			sat_val = acc[SUM_W-1:0];
		end else if (acc[ACC_W-1]) begin
			sat_val = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(SUM_W-1){1'b1}}};
		end
	end

	assign wr_m1 = tgt_s3 - DW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DEGREE; i++) begin
				sums_q[i] <= '0;
			end
			ov_q <= 1'b0;
		end else if (emit_fire) begin
			for (int i = 0; i < MAX_DEGREE; i++) begin
				sums_q[i] <= '0;
			end
			ov_q <= 1'b0;
		end else if (v_s3) begin
			sums_q[wr_m1[IW-1:0]] <= sat_val;
			if (sat_hit) begin
				ov_q <= 1'b1;
			end
		end
	end

	// hold e_d as it is written, so the result needs no second read port
	always_ff @(posedge clk) begin
		if (v_s3 && tgt_s3 == d_eff) begin
			kres_q <= sat_val;
		end
	end

	// output register
	logic [SUM_W-1:0] kv_q;
	logic             sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			kv_q  <= kres_q;
			sat_q <= ov_q;
		end
	end

	assign m_tdata = kv_q;
	assign m_tuser = sat_q;

`ifndef SYNTHESIS
	// the drain must be long enough: nothing still in flight at emit time
	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_EMIT) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("sum update still in flight at emit");

	// top sum is read only after the previous word fully retired
	a_prod_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_PROD) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("product step overlaps previous updates");

	a_take_then_prod: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (step_q == ST_PROD))
		else $error("accepted word not followed by product step");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (tgt_s3 != '0 && tgt_s3 <= d_eff))
		else $error("sum write outside active degree");
`endif

endmodule

`default_nettype wire
